@@ hw/rtl/asegm_pkg.sv @@
package asegm_pkg;

	// overlap tolerance register
	localparam int TOL_W = 7;
	localparam logic [TOL_W-1:0] TOL_RESET = 7'd5;

	// tolerance is given in percent
	localparam int PCT = 100;

	// per-cell control, driven by the top level
	typedef struct packed {
		logic             wr;
		logic [TOL_W-1:0] tol;
	} cell_ctl_t;

endpackage

@@ hw/rtl/asegm_cell.sv @@
// One cell of the comparison chain: holds one stored segment, checks the passing request
// against it over two register stages and hands the request on to its neighbour.
module asegm_cell #(
	parameter int POS_WIDTH = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  asegm_pkg::cell_ctl_t      ctl,
	input  logic [POS_WIDTH-1:0]      wr_qs,
	input  logic [POS_WIDTH-1:0]      wr_qe,
	input  logic [POS_WIDTH-1:0]      wr_ss,
	input  logic [POS_WIDTH-1:0]      wr_se,
	input  logic signed [POS_WIDTH+1:0] wr_lq,
	input  logic signed [POS_WIDTH+1:0] wr_ls,
	input  logic                      in_vld,
	input  logic [POS_WIDTH-1:0]      in_qs,
	input  logic [POS_WIDTH-1:0]      in_qe,
	input  logic [POS_WIDTH-1:0]      in_ss,
	input  logic [POS_WIDTH-1:0]      in_se,
	input  logic signed [POS_WIDTH+1:0] in_lq,
	input  logic signed [POS_WIDTH+1:0] in_ls,
	output logic                      out_vld,
	output logic [POS_WIDTH-1:0]      out_qs,
	output logic [POS_WIDTH-1:0]      out_qe,
	output logic [POS_WIDTH-1:0]      out_ss,
	output logic [POS_WIDTH-1:0]      out_se,
	output logic signed [POS_WIDTH+1:0] out_lq,
	output logic signed [POS_WIDTH+1:0] out_ls,
	output logic                      hit
);

	localparam int LW = POS_WIDTH + 2;
	localparam int UW = POS_WIDTH + 1;
	localparam int PW = POS_WIDTH + 1 + asegm_pkg::TOL_W;

	// stored segment
	logic [POS_WIDTH-1:0] st_qs_q, st_qe_q, st_ss_q, st_se_q;
	logic signed [LW-1:0] st_lq_q, st_ls_q;

	// request handed on to the neighbour
	logic                 nx_vld_q;
	logic [POS_WIDTH-1:0] nx_qs_q, nx_qe_q, nx_ss_q, nx_se_q;
	logic signed [LW-1:0] nx_lq_q, nx_ls_q;

	// first stage: overlaps and shorter lengths
	logic                 st_first;
	logic signed [LW-1:0] ovq_n, ovs_n, lq_min, ls_min;
	logic                 skip_n;
	logic                 a_vld_q, skip_a_q;
	logic signed [LW-1:0] ovq_a_q, ovs_a_q;
	logic [UW-1:0]        lq_a_q, ls_a_q;

	// second stage: cross-multiplied tolerance test
	logic          ovq_pos, ovs_pos, tq, ts;
	logic [PW-1:0] q_lhs, q_rhs, s_lhs, s_rhs;
	logic          hit_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			st_qs_q <= wr_qs;
			st_qe_q <= wr_qe;
			st_ss_q <= wr_ss;
			st_se_q <= wr_se;
			st_lq_q <= wr_lq;
			st_ls_q <= wr_ls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_vld_q <= 1'b0;
			a_vld_q  <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			nx_vld_q <= in_vld;
			a_vld_q  <= in_vld;
			if (a_vld_q) begin
				hit_q <= !skip_a_q && (tq || ts);
			end
		end
	end

	always_ff @(posedge clk) begin
		nx_qs_q  <= in_qs;
		nx_qe_q  <= in_qe;
		nx_ss_q  <= in_ss;
		nx_se_q  <= in_se;
		nx_lq_q  <= in_lq;
		nx_ls_q  <= in_ls;
		ovq_a_q  <= ovq_n;
		ovs_a_q  <= ovs_n;
		lq_a_q   <= lq_min[UW-1:0];
		ls_a_q   <= ls_min[UW-1:0];
		skip_a_q <= skip_n;
	end

	// order both segments by query start; the stored one is first only if strictly smaller
	assign st_first = st_qs_q < in_qs;

	always_comb begin
		if (st_first) begin
			ovq_n = {2'b00, st_qe_q} + LW'(1) - {2'b00, in_qs};
			ovs_n = {2'b00, st_se_q} + LW'(1) - {2'b00, in_ss};
		end else begin
			ovq_n = {2'b00, in_qe} + LW'(1) - {2'b00, st_qs_q};
			ovs_n = {2'b00, in_se} + LW'(1) - {2'b00, st_ss_q};
		end
		lq_min = (st_lq_q < in_lq) ? st_lq_q : in_lq;
		ls_min = (st_ls_q < in_ls) ? st_ls_q : in_ls;
		// drop the comparison when a shorter length is not positive
		skip_n = lq_min[LW-1] || (lq_min == '0) || ls_min[LW-1] || (ls_min == '0);
	end

	always_comb begin
		ovq_pos = !ovq_a_q[LW-1] && (ovq_a_q != '0);
		ovs_pos = !ovs_a_q[LW-1] && (ovs_a_q != '0);
		q_lhs   = PW'(ovq_a_q[UW-1:0]) * PW'(asegm_pkg::PCT);
		s_lhs   = PW'(ovs_a_q[UW-1:0]) * PW'(asegm_pkg::PCT);
		q_rhs   = PW'(ctl.tol) * PW'(lq_a_q);
		s_rhs   = PW'(ctl.tol) * PW'(ls_a_q);
		tq      = ovq_pos && (q_lhs > q_rhs);
		ts      = ovs_pos && (s_lhs > s_rhs);
	end

	assign out_vld = nx_vld_q;
	assign out_qs  = nx_qs_q;
	assign out_qe  = nx_qe_q;
	assign out_ss  = nx_ss_q;
	assign out_se  = nx_se_q;
	assign out_lq  = nx_lq_q;
	assign out_ls  = nx_ls_q;
	assign hit     = hit_q;

endmodule

@@ hw/rtl/alignment_segment_merger.sv @@
// Alignment segment merger: collects the local alignment segments of one query/subject pair.
// Request channel: pulse start with the segment fields while busy is low; the request is
// taken at that edge and busy rises until the result has been issued. A request with
// new_pair set, or any request while nothing is stored, opens a new pair and is stored as is.
// Any other request walks a chain of MAX_SEGMENTS cells, one cell a cycle, each holding one
// stored segment and testing it for overlap beyond the tolerance; if no live cell objects and
// the store has room, the segment is stored and the totals and spans are updated.
// Result channel: done is high for exactly one cycle with all result fields valid; the
// receiver cannot hold results off, so the result must be taken in that cycle.
// Sequencing: a request that opens a pair goes through S_UPD and S_OUT, and done rises as
// the block returns to S_IDLE. Other requests first pass through S_SCAN while they walk
// the whole cell chain, then S_UPD and S_OUT. In both cases busy stays high until done, so
// the block takes no new request before it has issued the result of the last one.
// Configuration: an APB port holds overlap_tolerance_pct at byte address 0; write only
// while busy is low and no result is pending.
// Reset: arst_n clears the store count, totals and the control state, and sets the
// tolerance to 5 percent. The segment cells are not cleared; they are only read below the
// stored count.
module alignment_segment_merger #(
	parameter int MAX_SEGMENTS = 16,
	parameter int POS_WIDTH    = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        start,
	output logic        busy,
	input  logic        new_pair,
	input  logic [23:0] query_start,
	input  logic [23:0] query_end,
	input  logic [23:0] subject_start,
	input  logic [23:0] subject_end,
	input  logic [23:0] segment_length,
	input  logic [23:0] score_tenths,
	input  logic [23:0] identities,
	input  logic [23:0] gap_count,
	// result channel
	output logic        done,
	output logic        accepted,
	output logic        store_full,
	output logic [7:0]  merge_count,
	output logic [7:0]  segment_count,
	output logic [31:0] total_length,
	output logic [31:0] total_score_tenths,
	output logic [31:0] total_identities,
	output logic [31:0] total_gaps,
	output logic [24:0] query_span,
	output logic [24:0] subject_span,
	output logic [31:0] query_covered,
	output logic [31:0] subject_covered,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int LW  = POS_WIDTH + 2;
	localparam int PW1 = POS_WIDTH + 1;
	localparam int CW  = $clog2(MAX_SEGMENTS + 1);
	localparam int IW  = $clog2(MAX_SEGMENTS);

	// register index, taken from paddr[2]
	localparam logic REG_TOL = 1'b0;
	localparam logic REG_NONE = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPD,
		S_OUT
	} state_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] b);
		logic [33:0] s;
		s = {2'b00, a} + {1'b0, b};
		return (s > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [24:0] span_of(input logic [POS_WIDTH-1:0] lo,
		input logic [POS_WIDTH-1:0] hi);
		logic [PW1-1:0] d;
		d = {1'b0, hi} - {1'b0, lo} + PW1'(1);
		return (hi >= lo) ? 25'(d) : 25'd0;
	endfunction

	// ---------------------------------------------------------------- configuration
	logic [asegm_pkg::TOL_W-1:0] tol_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= asegm_pkg::TOL_RESET;
		end else if (cfg_wr && (paddr[2] == REG_TOL)) begin
			tol_q <= pwdata[asegm_pkg::TOL_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TOL:  prdata = 32'(tol_q);
			REG_NONE: prdata = 32'd0;
			default:  prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------- control
	state_t          state_q;
	logic [CW-1:0]   scan_cnt_q;
	logic            done_q, acc_q, full_q;
	logic            take, fresh_n;

	// pair state
	logic [CW-1:0]        count_q;
	logic [7:0]           merges_q;
	logic [31:0]          sum_len_q, sum_sc_q, sum_id_q, sum_gap_q, sum_qc_q, sum_sc_cov_q;
	logic [POS_WIDTH-1:0] qmin_q, qmax_q, smin_q, smax_q;

	// held request
	logic                 fresh_q;
	logic [POS_WIDTH-1:0] it_qs_q, it_qe_q, it_ss_q, it_se_q;
	logic signed [LW-1:0] it_lq_q, it_ls_q;
	logic [23:0]          it_len_q, it_sc_q, it_id_q, it_gap_q;

	// request as it enters, masked to the position width
	logic [POS_WIDTH-1:0] qs_m, qe_m, ss_m, se_m;

	assign busy    = (state_q != S_IDLE);
	assign take    = start && !busy;
	assign fresh_n = new_pair || (count_q == '0);

	assign qs_m = POS_WIDTH'(query_start);
	assign qe_m = POS_WIDTH'(query_end);
	assign ss_m = POS_WIDTH'(subject_start);
	assign se_m = POS_WIDTH'(subject_end);

	always_ff @(posedge clk) begin
		if (take) begin
			fresh_q  <= fresh_n;
			it_qs_q  <= qs_m;
			it_qe_q  <= qe_m;
			it_ss_q  <= ss_m;
			it_se_q  <= se_m;
			it_lq_q  <= {2'b00, qe_m} - {2'b00, qs_m} + LW'(1);
			it_ls_q  <= {2'b00, se_m} - {2'b00, ss_m} + LW'(1);
			it_len_q <= segment_length;
			it_sc_q  <= score_tenths;
			it_id_q  <= identities;
			it_gap_q <= gap_count;
		end
	end

	// ---------------------------------------------------------------- decision
	logic [MAX_SEGMENTS-1:0] hit_vec, use_vec;
	logic                    rej, full_c, acc_n, full_n;
	logic [IW-1:0]           widx;
	logic [32:0]             qcov_amt, scov_amt;

	assign rej    = |(hit_vec & use_vec);
	assign full_c = count_q >= CW'(MAX_SEGMENTS);
	assign acc_n  = fresh_q || (!rej && !full_c);
	assign full_n = !fresh_q && !rej && full_c;
	assign widx   = fresh_q ? '0 : count_q[IW-1:0];

	// range lengths for coverage: zero when start lies above end
	assign qcov_amt = (it_lq_q[LW-1] || (it_lq_q == '0)) ? 33'd0 : 33'(it_lq_q[PW1-1:0]);
	assign scov_amt = (it_ls_q[LW-1] || (it_ls_q == '0)) ? 33'd0 : 33'(it_ls_q[PW1-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			scan_cnt_q <= '0;
			done_q     <= 1'b0;
			acc_q      <= 1'b0;
			full_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						scan_cnt_q <= '0;
						state_q    <= fresh_n ? S_UPD : S_SCAN;
					end
				end
				S_SCAN: begin
					// hold until the last cell has reported
					if (scan_cnt_q == CW'(MAX_SEGMENTS)) begin
						state_q <= S_UPD;
					end else begin
						scan_cnt_q <= scan_cnt_q + CW'(1);
					end
				end
				S_UPD: begin
					acc_q   <= acc_n;
					full_q  <= full_n;
					state_q <= S_OUT;
				end
				S_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// advance the pair state when a segment is taken; a new pair starts from zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			merges_q     <= '0;
			sum_len_q    <= '0;
			sum_sc_q     <= '0;
			sum_id_q     <= '0;
			sum_gap_q    <= '0;
			sum_qc_q     <= '0;
			sum_sc_cov_q <= '0;
			qmin_q       <= '0;
			qmax_q       <= '0;
			smin_q       <= '0;
			smax_q       <= '0;
		end else if ((state_q == S_UPD) && acc_n) begin
			if (fresh_q) begin
				count_q      <= CW'(1);
				merges_q     <= '0;
				sum_len_q    <= sat_add(32'd0, 33'(it_len_q));
				sum_sc_q     <= sat_add(32'd0, 33'(it_sc_q));
				sum_id_q     <= sat_add(32'd0, 33'(it_id_q));
				sum_gap_q    <= sat_add(32'd0, 33'(it_gap_q));
				sum_qc_q     <= sat_add(32'd0, qcov_amt);
				sum_sc_cov_q <= sat_add(32'd0, scov_amt);
				qmin_q       <= it_qs_q;
				qmax_q       <= it_qe_q;
				smin_q       <= it_ss_q;
				smax_q       <= it_se_q;
			end else begin
				count_q      <= count_q + CW'(1);
				if (merges_q != 8'hFF) begin
					merges_q <= merges_q + 8'd1;
				end
				sum_len_q    <= sat_add(sum_len_q, 33'(it_len_q));
				sum_sc_q     <= sat_add(sum_sc_q, 33'(it_sc_q));
				sum_id_q     <= sat_add(sum_id_q, 33'(it_id_q));
				sum_gap_q    <= sat_add(sum_gap_q, 33'(it_gap_q));
				sum_qc_q     <= sat_add(sum_qc_q, qcov_amt);
				sum_sc_cov_q <= sat_add(sum_sc_cov_q, scov_amt);
				if (it_qs_q < qmin_q) qmin_q <= it_qs_q;
				if (it_qe_q > qmax_q) qmax_q <= it_qe_q;
				if (it_ss_q < smin_q) smin_q <= it_ss_q;
				if (it_se_q > smax_q) smax_q <= it_se_q;
			end
		end
	end

	// spans from the updated bounds
	logic [24:0] qspan_q, sspan_q;

	always_ff @(posedge clk) begin
		if (state_q == S_OUT) begin
			qspan_q <= (count_q == '0) ? 25'd0 : span_of(qmin_q, qmax_q);
			sspan_q <= (count_q == '0) ? 25'd0 : span_of(smin_q, smax_q);
		end
	end

	// ---------------------------------------------------------------- cell chain
	logic                 ch_vld [MAX_SEGMENTS];
	logic [POS_WIDTH-1:0] ch_qs  [MAX_SEGMENTS];
	logic [POS_WIDTH-1:0] ch_qe  [MAX_SEGMENTS];
	logic [POS_WIDTH-1:0] ch_ss  [MAX_SEGMENTS];
	logic [POS_WIDTH-1:0] ch_se  [MAX_SEGMENTS];
	logic signed [LW-1:0] ch_lq  [MAX_SEGMENTS];
	logic signed [LW-1:0] ch_ls  [MAX_SEGMENTS];

	// launch the held request into the head cell for one cycle
	assign ch_vld[0] = (state_q == S_SCAN) && (scan_cnt_q == '0);
	assign ch_qs[0]  = it_qs_q;
	assign ch_qe[0]  = it_qe_q;
	assign ch_ss[0]  = it_ss_q;
	assign ch_se[0]  = it_se_q;
	assign ch_lq[0]  = it_lq_q;
	assign ch_ls[0]  = it_ls_q;

	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		asegm_pkg::cell_ctl_t ctl;

		assign ctl.wr     = (state_q == S_UPD) && acc_n && (widx == IW'(i));
		assign ctl.tol    = tol_q;
		assign use_vec[i] = CW'(i) < count_q;

		if (i < MAX_SEGMENTS - 1) begin : g_mid
			asegm_cell #(.POS_WIDTH(POS_WIDTH)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.wr_qs  (it_qs_q),
				.wr_qe  (it_qe_q),
				.wr_ss  (it_ss_q),
				.wr_se  (it_se_q),
				.wr_lq  (it_lq_q),
				.wr_ls  (it_ls_q),
				.in_vld (ch_vld[i]),
				.in_qs  (ch_qs[i]),
				.in_qe  (ch_qe[i]),
				.in_ss  (ch_ss[i]),
				.in_se  (ch_se[i]),
				.in_lq  (ch_lq[i]),
				.in_ls  (ch_ls[i]),
				.out_vld(ch_vld[i+1]),
				.out_qs (ch_qs[i+1]),
				.out_qe (ch_qe[i+1]),
				.out_ss (ch_ss[i+1]),
				.out_se (ch_se[i+1]),
				.out_lq (ch_lq[i+1]),
				.out_ls (ch_ls[i+1]),
				.hit    (hit_vec[i])
			);
		end else begin : g_last
			asegm_cell #(.POS_WIDTH(POS_WIDTH)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.wr_qs  (it_qs_q),
				.wr_qe  (it_qe_q),
				.wr_ss  (it_ss_q),
				.wr_se  (it_se_q),
				.wr_lq  (it_lq_q),
				.wr_ls  (it_ls_q),
				.in_vld (ch_vld[i]),
				.in_qs  (ch_qs[i]),
				.in_qe  (ch_qe[i]),
				.in_ss  (ch_ss[i]),
				.in_se  (ch_se[i]),
				.in_lq  (ch_lq[i]),
				.in_ls  (ch_ls[i]),
				.out_vld(),
				.out_qs (),
				.out_qe (),
				.out_ss (),
				.out_se (),
				.out_lq (),
				.out_ls (),
				.hit    (hit_vec[i])
			);
		end
	end

	// ---------------------------------------------------------------- result
	assign done               = done_q;
	assign accepted           = acc_q;
	assign store_full         = full_q;
	assign merge_count        = merges_q;
	assign segment_count      = 8'(count_q);
	assign total_length       = sum_len_q;
	assign total_score_tenths = sum_sc_q;
	assign total_identities   = sum_id_q;
	assign total_gaps         = sum_gap_q;
	assign query_span         = qspan_q;
	assign subject_span       = sspan_q;
	assign query_covered      = sum_qc_q;
	assign subject_covered    = sum_sc_cov_q;

	// ---------------------------------------------------------------- checks
	a_full_not_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && store_full) |-> !accepted)
		else $error("store_full reported on an accepted segment");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (segment_count <= 8'(MAX_SEGMENTS)))
		else $error("segment count beyond store depth");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("request taken without going busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result issued while still busy");

endmodule

@@ tb/alignment_segment_merger_test.sv @@
`timescale 1ns / 1ps

module alignment_segment_merger_test;
	import asegm_pkg::*;

	localparam int MAXSEG = 16;
	// long enough for a walk through the cell chain and the update and output states
	localparam int SETTLE_CYCLES = MAXSEG + 4;
	localparam logic [2:0] TOL_REG_ADDR = 3'd0;
	localparam logic [23:0] POS_MAX = 24'hFFFFFF;

	// one result as it leaves the block, in port order
	typedef struct packed {
		logic        acc;
		logic        full;
		logic [7:0]  merges;
		logic [7:0]  segs;
		logic [31:0] len;
		logic [31:0] score;
		logic [31:0] ids;
		logic [31:0] gaps;
		logic [24:0] qspan;
		logic [24:0] sspan;
		logic [31:0] qcov;
		logic [31:0] scov;
	} merge_result_t;

	// one request; the last four fields carry a hand-typed expectation where known
	typedef struct {
		bit        np;
		bit [23:0] qs;
		bit [23:0] qe;
		bit [23:0] ss;
		bit [23:0] se;
		bit [23:0] len;
		bit [23:0] score;
		bit [23:0] ids;
		bit [23:0] gaps;
		bit        typed;
		bit        t_acc;
		bit        t_full;
		bit [7:0]  t_segs;
	} stim_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        new_pair = 1'b0;
	logic [23:0] query_start = '0;
	logic [23:0] query_end = '0;
	logic [23:0] subject_start = '0;
	logic [23:0] subject_end = '0;
	logic [23:0] segment_length = '0;
	logic [23:0] score_tenths = '0;
	logic [23:0] identities = '0;
	logic [23:0] gap_count = '0;
	logic        done;
	logic        accepted;
	logic        store_full;
	logic [7:0]  merge_count;
	logic [7:0]  segment_count;
	logic [31:0] total_length;
	logic [31:0] total_score_tenths;
	logic [31:0] total_identities;
	logic [31:0] total_gaps;
	logic [24:0] query_span;
	logic [24:0] subject_span;
	logic [31:0] query_covered;
	logic [31:0] subject_covered;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	alignment_segment_merger dut (.*);

	// ---------------------------------------------------------------
	// Predictor state: a private copy of the segment store, counters,
	// saturating totals, span bounds and the tolerance register.
	// ---------------------------------------------------------------
	bit [23:0]       held_qs [MAXSEG];
	bit [23:0]       held_qe [MAXSEG];
	bit [23:0]       held_ss [MAXSEG];
	bit [23:0]       held_se [MAXSEG];
	int unsigned     held_count = 0;
	int unsigned     merges_seen = 0;
	bit [31:0]       sums [6];      // length, score, ids, gaps, query cover, subject cover
	bit [23:0]       bounds [4];    // query min/max, subject min/max
	bit [TOL_W-1:0]  tol_pct = TOL_RESET;

	merge_result_t   totals_due [$];   // results still owed by the block, oldest first
	int              mismatches = 0;

	function automatic bit [31:0] sat_sum(bit [31:0] a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// inclusive length of a range, zero when start lies above end
	function automatic longint unsigned extent(bit [23:0] s, bit [23:0] e);
		return (e >= s) ? longint'(e) - longint'(s) + 1 : 0;
	endfunction

	// first range ends at e1, second starts at s2; overlap beyond the tolerance of the
	// shorter length rejects
	function automatic bit axis_clash(longint s1, longint e1, longint s2, longint e2);
		longint l1, l2, shorter, ov, tl;
		l1 = e1 - s1 + 1;
		l2 = e2 - s2 + 1;
		shorter = (l1 < l2) ? l1 : l2;
		ov = e1 + 1 - s2;
		tl = tol_pct;
		return ov * PCT > tl * shorter;
	endfunction

	// order by query start (stored one first only if strictly smaller) and keep that
	// order for the subject axis as well
	function automatic bit clashes(int idx, stim_row_t r);
		longint fqs, fqe, fss, fse, gqs, gqe, gss, gse, lq1, lq2, ls1, ls2;
		if (held_qs[idx] < r.qs) begin
			fqs = held_qs[idx]; fqe = held_qe[idx]; fss = held_ss[idx]; fse = held_se[idx];
			gqs = r.qs; gqe = r.qe; gss = r.ss; gse = r.se;
		end else begin
			fqs = r.qs; fqe = r.qe; fss = r.ss; fse = r.se;
			gqs = held_qs[idx]; gqe = held_qe[idx]; gss = held_ss[idx]; gse = held_se[idx];
		end
		lq1 = fqe - fqs + 1;
		lq2 = gqe - gqs + 1;
		ls1 = fse - fss + 1;
		ls2 = gse - gss + 1;
		// a reversed range on either side skips this stored segment
		if (((lq1 < lq2) ? lq1 : lq2) <= 0 || ((ls1 < ls2) ? ls1 : ls2) <= 0)
			return 1'b0;
		return axis_clash(fqs, fqe, gqs, gqe) || axis_clash(fss, fse, gss, gse);
	endfunction

	// advance the predictor by one request and return the totals it should report
	function automatic merge_result_t merge_segment(stim_row_t r);
		merge_result_t res;
		bit acc, full, fresh;
		int i;
		acc = 1'b1;
		full = 1'b0;
		fresh = r.np || held_count == 0;
		if (fresh) begin
			held_count = 0;
			merges_seen = 0;
			foreach (sums[k]) sums[k] = '0;
			bounds[0] = r.qs; bounds[1] = r.qe;
			bounds[2] = r.ss; bounds[3] = r.se;
		end else begin
			for (i = 0; i < held_count; i++) begin
				if (clashes(i, r)) begin
					acc = 1'b0;
					break;
				end
			end
			if (acc && held_count >= MAXSEG) begin
				acc = 1'b0;
				full = 1'b1;
			end
			if (acc) begin
				if (merges_seen < 255) merges_seen++;
				if (r.qs < bounds[0]) bounds[0] = r.qs;
				if (r.qe > bounds[1]) bounds[1] = r.qe;
				if (r.ss < bounds[2]) bounds[2] = r.ss;
				if (r.se > bounds[3]) bounds[3] = r.se;
			end
		end
		if (acc) begin
			held_qs[held_count] = r.qs;
			held_qe[held_count] = r.qe;
			held_ss[held_count] = r.ss;
			held_se[held_count] = r.se;
			held_count++;
			sums[0] = sat_sum(sums[0], r.len);
			sums[1] = sat_sum(sums[1], r.score);
			sums[2] = sat_sum(sums[2], r.ids);
			sums[3] = sat_sum(sums[3], r.gaps);
			sums[4] = sat_sum(sums[4], extent(r.qs, r.qe));
			sums[5] = sat_sum(sums[5], extent(r.ss, r.se));
		end
		res.acc = acc;
		res.full = full;
		res.merges = merges_seen[7:0];
		res.segs = held_count[7:0];
		res.len = sums[0];
		res.score = sums[1];
		res.ids = sums[2];
		res.gaps = sums[3];
		res.qspan = held_count ? extent(bounds[0], bounds[1]) : '0;
		res.sspan = held_count ? extent(bounds[2], bounds[3]) : '0;
		res.qcov = sums[4];
		res.scov = sums[5];
		return res;
	endfunction

	function automatic string show_totals(merge_result_t t);
		return $sformatf({"acc=%0b full=%0b merges=%0d segs=%0d len=%h score=%h ids=%h",
			" gaps=%h qspan=%h sspan=%h qcov=%h scov=%h"},
			t.acc, t.full, t.merges, t.segs, t.len, t.score, t.ids, t.gaps,
			t.qspan, t.sspan, t.qcov, t.scov);
	endfunction

	// count every fault, print only the first ten
	function automatic void note_fault(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	// Clock: 12 ns period.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result watcher: a result lives for one cycle only, so take it at
	// the edge that closes the done cycle and compare it against the
	// oldest outstanding expectation.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : watch_totals
		merge_result_t got, want;
		if (arst_n && done) begin
			got = {accepted, store_full, merge_count, segment_count, total_length,
				total_score_tenths, total_identities, total_gaps, query_span,
				subject_span, query_covered, subject_covered};
			if (totals_due.size() == 0) begin
				note_fault($sformatf("result with no request pending: %s", show_totals(got)));
			end else begin
				want = totals_due.pop_front();
				if (got !== want)
					note_fault($sformatf("result mismatch\n  expected %s\n  actual   %s",
						show_totals(want), show_totals(got)));
			end
		end
	end

	// Present one request, hold it until the block takes it, record the expected totals,
	// then optionally idle the request side for a burst of cycles.
	task automatic issue(input stim_row_t r, input int gap);
		merge_result_t want;
		new_pair <= r.np;
		query_start <= r.qs;
		query_end <= r.qe;
		subject_start <= r.ss;
		subject_end <= r.se;
		segment_length <= r.len;
		score_tenths <= r.score;
		identities <= r.ids;
		gap_count <= r.gaps;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		want = merge_segment(r);
		// a hand-typed row overrides the flags and count it spells out
		if (r.typed) begin
			want.acc = r.t_acc;
			want.full = r.t_full;
			want.segs = r.t_segs;
		end
		totals_due.push_back(want);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start, drain every outstanding result and let the block fall quiet.
	task automatic settle();
		start <= 1'b0;
		while (totals_due.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the tolerance register over APB, then read it back.
	task automatic set_tolerance(input logic [TOL_W-1:0] val);
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TOL_REG_ADDR;
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		@(posedge clk);
		// register takes the value at this edge
		tol_pct = val;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		rd = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== 32'(val))
			note_fault($sformatf("tolerance readback %h, wrote %h", rd, val));
	endtask

	function automatic bit [23:0] pick_amount();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return POS_MAX;
			default: return $urandom();
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Random phase: mostly well-formed runs of segments per pair, laid
	// end to end with a small overlap around the tolerance, in either
	// direction on each axis. Mixed in: heavy overlaps, reversed ranges
	// and pure noise. Pairs often run past the store depth.
	// ---------------------------------------------------------------
	task automatic run_phase(input int n_items, input bit may_idle);
		stim_row_t r, last;
		int left, plen, j, kind, gap;
		bit qup, sup, quiet;
		bit [23:0] qcur, scur, ln, sln, ov, sov, tmp;
		left = n_items;
		quiet = 1'b0;
		last = '{default: '0};
		while (left > 0) begin
			plen = $urandom_range(1, 20);
			qup = $urandom_range(0, 1);
			sup = ($urandom_range(0, 3) == 0) ? !qup : qup;
			qcur = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(100000, 300000);
			scur = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(100000, 300000);
			for (j = 0; j < plen && left > 0; j++) begin
				r = '{default: '0};
				r.np = (j == 0) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 49) == 0);
				kind = $urandom_range(0, 99);
				case ($urandom_range(0, 9))
					0: ln = 24'd1;
					1: ln = $urandom_range(1, 60000);
					default: ln = $urandom_range(2, 400);
				endcase
				sln = ln + 24'($urandom_range(0, 4));
				if (kind < 90) begin
					ov = ($urandom_range(0, 2) == 0) ? '0 : 24'($urandom_range(0, ln / 8 + 1));
					sov = ($urandom_range(0, 2) == 0) ? '0 : 24'($urandom_range(0, sln / 8 + 1));
					if (qup) begin
						r.qs = qcur - ov; r.qe = r.qs + ln - 1; qcur = r.qe + 1;
					end else begin
						r.qe = qcur - 1 + ov; r.qs = r.qe - ln + 1; qcur = r.qs;
					end
					if (sup) begin
						r.ss = scur - sov; r.se = r.ss + sln - 1; scur = r.se + 1;
					end else begin
						r.se = scur - 1 + sov; r.ss = r.se - sln + 1; scur = r.ss;
					end
					if (kind >= 70 && kind < 80) begin
						// land on top of the previous segment
						r.qs = last.qs + 24'($urandom_range(0, 40));
						r.qe = r.qs + ln - 1;
						r.ss = last.ss + 24'($urandom_range(0, 40));
						r.se = r.ss + sln - 1;
					end else if (kind >= 80) begin
						// reverse one axis
						if ($urandom_range(0, 1)) begin
							tmp = r.qs; r.qs = r.qe; r.qe = tmp;
						end else begin
							tmp = r.ss; r.ss = r.se; r.se = tmp;
						end
					end
				end else begin
					r.qs = $urandom(); r.qe = $urandom();
					r.ss = $urandom(); r.se = $urandom();
				end
				r.len = pick_amount();
				r.score = pick_amount();
				r.ids = pick_amount();
				r.gaps = pick_amount();
				// idling comes in stretches, with quiet stretches in between
				if (left % 25 == 0) quiet = ($urandom_range(0, 2) == 0);
				gap = (may_idle && !quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
				issue(r, gap);
				last = r;
				left--;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Main sequence: reset, directed rows, then random phases each at a
	// new tolerance, the last one without idling.
	// ---------------------------------------------------------------
	initial begin : stimulus
		stim_row_t rows [$];
		stim_row_t r;
		bit [TOL_W-1:0] tol_plan [6];
		int k;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tolerance stays at its reset value of 5 percent here
		// empty store: a request without new_pair still opens the pair
		rows.push_back(stim_row_t'{1'b0, 24'd100, 24'd199, 24'd1000, 24'd1099,
			24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1, 1'b0, 8'd1});
		// heavy overlap on both axes: reject
		rows.push_back(stim_row_t'{1'b0, 24'd150, 24'd249, 24'd1050, 24'd1149,
			24'd7, 24'd8, 24'd9, 24'd10, 1'b1, 1'b0, 1'b0, 8'd1});
		// overlap of exactly the tolerance: still taken
		rows.push_back(stim_row_t'{1'b0, 24'd195, 24'd294, 24'd1095, 24'd1194,
			24'd100, 24'd555, 24'd97, 24'd2, 1'b1, 1'b1, 1'b0, 8'd2});
		// query after, subject before: ordered by query, the subject clash rejects
		rows.push_back(stim_row_t'{1'b0, 24'd5000, 24'd5099, 24'd300, 24'd399,
			24'd100, 24'd10, 24'd10, 24'd1, 1'b0, 1'b0, 1'b0, 8'd0});
		// query start above end: taken, counts zero coverage
		rows.push_back(stim_row_t'{1'b0, 24'd3000, 24'd2000, 24'd7000, 24'd7099,
			24'd1, 24'd2, 24'd3, 24'd4, 1'b1, 1'b1, 1'b0, 8'd3});
		// the reversed stored range is skipped in the comparison
		rows.push_back(stim_row_t'{1'b0, 24'd2500, 24'd2600, 24'd7050, 24'd7149,
			24'd101, 24'd900, 24'd99, 24'd0, 1'b0, 1'b0, 1'b0, 8'd0});
		// widest ranges and largest amounts open a new pair
		rows.push_back(stim_row_t'{1'b1, 24'd0, POS_MAX, 24'd0, POS_MAX,
			POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b1, 1'b1, 1'b0, 8'd1});
		// one position at the top end overlaps by one: reject
		rows.push_back(stim_row_t'{1'b0, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
			POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b1, 1'b0, 1'b0, 8'd1});
		// fill the store with sixteen disjoint segments, the last reaching the top end
		for (k = 0; k < MAXSEG; k++) begin
			r = '{default: '0};
			r.np = (k == 0);
			r.qs = (k == MAXSEG - 1) ? 24'd20000 : 24'(k * 1000);
			r.qe = (k == MAXSEG - 1) ? POS_MAX : 24'(k * 1000 + 999);
			r.ss = r.qs;
			r.se = r.qe;
			r.len = $urandom();
			r.score = $urandom();
			r.ids = $urandom();
			r.gaps = $urandom();
			r.typed = 1'b1;
			r.t_acc = 1'b1;
			r.t_segs = 8'(k + 1);
			rows.push_back(r);
		end
		// clean segment with the store full: flagged
		rows.push_back(stim_row_t'{1'b0, 24'd16000, 24'd16999, 24'd16000, 24'd16999,
			24'd5, 24'd5, 24'd5, 24'd5, 1'b1, 1'b0, 1'b1, 8'd16});
		// clashing segment with the store full: plain reject, no flag
		rows.push_back(stim_row_t'{1'b0, 24'd0, 24'd999, 24'd0, 24'd999,
			24'd5, 24'd5, 24'd5, 24'd5, 1'b1, 1'b0, 1'b0, 8'd16});

		foreach (rows[i])
			issue(rows[i], ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0);

		// zero, top of the field, full percent, a random value between, 20 percent, then back to reset
		tol_plan = '{7'd0, 7'd127, 7'd100, 7'd0, 7'd20, TOL_RESET};
		tol_plan[3] = $urandom_range(1, 99);
		for (k = 0; k < 6; k++) begin
			settle();
			set_tolerance(tol_plan[k]);
			run_phase((k == 5) ? 80 : 90, k != 5);
		end

		// drain and allow the block's latency before the verdict
		settle();
		if (mismatches == 0 && totals_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/asegm_pkg.sv
hw/rtl/asegm_cell.sv
hw/rtl/alignment_segment_merger.sv
tb/alignment_segment_merger_test.sv
